FILE: design/linear_model_inference_top_defines.svh
// Assertion macros for the linear model inference block.
// Included by the checker; depends on nothing else.
`ifndef LINEAR_MODEL_INFERENCE_TOP_DEFINES_SVH
`define LINEAR_MODEL_INFERENCE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LMI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LMI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define LMI_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/lmi_pkg.sv
// Shared types and constants of the linear model inference block.
// No dependencies.
package lmi_pkg;

   localparam int ACC_W        = 48;
   localparam int SUM_W        = 49;
   localparam int DIV_NUM_W    = 49;
   localparam int DIV_DEN_W    = 34;
   localparam int DIV_QUO_W    = 32;
   localparam int TAYLOR_TERMS = 14;

   localparam logic [36:0]        LN2_Q32   = 37'd2977044472;
   localparam logic signed [48:0] SIG_LIMIT = 49'sd268435456;

   typedef enum logic [1:0] {
      FUNC_WEIGHT  = 2'd0,
      FUNC_BIAS    = 2'd1,
      FUNC_FEATURE = 2'd2
   } func_type;

   localparam logic [1:0] CSR_TASK_MODE     = 2'd0;
   localparam logic [1:0] CSR_FEATURE_COUNT = 2'd1;
   localparam logic [1:0] CSR_OUTPUT_COUNT  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_OUT_RD,
      ST_OUT_SUM,
      ST_OUT_CALC,
      ST_OUT_SIG,
      ST_OUT_VALID
   } lmi_state_type;

   typedef enum logic [2:0] {
      SG_IDLE,
      SG_KDIV,
      SG_MUL,
      SG_DIVS,
      SG_DIVW,
      SG_FIN,
      SG_FDW
   } sig_state_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
      logic [5:0]           bits;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_QUO_W-1:0] quo;
   } div_rsp_type;

   typedef struct packed {
      logic        done;
      logic [15:0] value;
   } sig_rsp_type;

endpackage

FILE: design/lmi_ram.sv
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
module lmi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/lmi_cell.sv
// One accumulator cell of the ring; takes its neighbor's value on shift.
// Depends on lmi_pkg.
module lmi_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  lmi_pkg::cell_ctl_type      cell_ctl,
   input  logic signed [lmi_pkg::ACC_W-1:0] cell_d,
   output logic signed [lmi_pkg::ACC_W-1:0] cell_q
);
   import lmi_pkg::*;

   logic signed [ACC_W-1:0] acc_ff, acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (cell_ctl.clear) begin
         acc_in = '0;
      end else if (cell_ctl.shift) begin
         acc_in = cell_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign cell_q = acc_ff;

endmodule

FILE: design/lmi_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on lmi_pkg.
module lmi_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lmi_pkg::div_req_type div_req,
   output lmi_pkg::div_rsp_type div_rsp
);
   import lmi_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_QUO_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, num_ff[DIV_NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.bits;
         num_in  = div_req.num;
         den_in  = div_req.den;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         num_in = {num_ff[DIV_NUM_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_QUO_W-2:0], fits};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

FILE: design/lmi_sigmoid.sv
// Sequenced logistic sigmoid: range reduction by ln 2, Taylor series for exp,
// then a final division. Depends on lmi_pkg and lmi_div.
module lmi_sigmoid (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             sig_start,
   input  logic signed [lmi_pkg::SUM_W-1:0] sig_arg,
   output lmi_pkg::sig_rsp_type             sig_rsp
);
   import lmi_pkg::*;

   sig_state_type state_ff, state_in;
   logic          neg_ff, neg_in;
   logic [36:0]   a_ff, a_in;
   logic [4:0]    k_ff, k_in;
   logic [2:0]    b_ff, b_in;
   logic [31:0]   term_ff, term_in;
   logic [33:0]   sum_ff, sum_in;
   logic [3:0]    n_ff, n_in;
   logic [31:0]   prod_ff, prod_in;
   logic [15:0]   res_ff, res_in;
   logic          done_ff, done_in;

   logic signed [SUM_W-1:0] arg_c, mag;
   logic [36:0]             step_cmp, a_step;
   logic                    step_fits;
   logic [63:0]             product;
   logic [33:0]             e_val, den_f, half_f;
   logic [DIV_NUM_W-1:0]    fnum;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   lmi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      // clamp the argument to plus or minus 16
      if (sig_arg > SIG_LIMIT) begin
         arg_c = SIG_LIMIT;
      end else if (sig_arg < -SIG_LIMIT) begin
         arg_c = -SIG_LIMIT;
      end else begin
         arg_c = sig_arg;
      end
      mag       = (arg_c < 0) ? -arg_c : arg_c;
      step_cmp  = LN2_Q32 << b_ff;
      step_fits = a_ff >= step_cmp;
      a_step    = step_fits ? (a_ff - step_cmp) : a_ff;
      product   = term_ff * a_ff[31:0];
      e_val     = sum_ff >> k_ff;
      den_f     = 34'h1_0000_0000 + e_val;
      half_f    = den_f >> 1;
      fnum      = neg_ff ? ({e_val[32:0], 16'b0} + DIV_NUM_W'(half_f))
                         : (49'h1_0000_0000_0000 + DIV_NUM_W'(half_f));

      state_in = state_ff;
      neg_in   = neg_ff;
      a_in     = a_ff;
      k_in     = k_ff;
      b_in     = b_ff;
      term_in  = term_ff;
      sum_in   = sum_ff;
      n_in     = n_ff;
      prod_in  = prod_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      div_req  = '0;

      case (state_ff)
         SG_IDLE: begin
            if (sig_start) begin
               neg_in   = arg_c < 0;
               a_in     = {mag[28:0], 8'b0};
               k_in     = '0;
               b_in     = 3'd4;
               state_in = SG_KDIV;
            end
         end
         SG_KDIV: begin
            a_in = a_step;
            k_in = k_ff | (5'(step_fits) << b_ff);
            if (b_ff == 3'd0) begin
               // first series term is r itself
               term_in  = a_step[31:0];
               sum_in   = 34'h1_0000_0000 - {2'b0, a_step[31:0]};
               n_in     = 4'd2;
               state_in = SG_MUL;
            end else begin
               b_in = b_ff - 3'd1;
            end
         end
         SG_MUL: begin
            prod_in  = product[63:32];
            state_in = SG_DIVS;
         end
         SG_DIVS: begin
            div_req.start = 1'b1;
            div_req.num   = {prod_ff, 17'b0};
            div_req.den   = DIV_DEN_W'(n_ff);
            div_req.bits  = 6'd32;
            state_in      = SG_DIVW;
         end
         SG_DIVW: begin
            if (div_rsp.done) begin
               term_in = div_rsp.quo;
               sum_in  = n_ff[0] ? (sum_ff - {2'b0, div_rsp.quo})
                                 : (sum_ff + {2'b0, div_rsp.quo});
               if (n_ff == 4'(TAYLOR_TERMS)) begin
                  state_in = SG_FIN;
               end else begin
                  n_in     = n_ff + 4'd1;
                  state_in = SG_MUL;
               end
            end
         end
         SG_FIN: begin
            div_req.start = 1'b1;
            div_req.num   = fnum;
            div_req.den   = den_f;
            div_req.bits  = 6'(DIV_NUM_W);
            state_in      = SG_FDW;
         end
         SG_FDW: begin
            if (div_rsp.done) begin
               if (!neg_ff && (div_rsp.quo > 32'd65535)) begin
                  res_in = 16'hFFFF;
               end else begin
                  res_in = div_rsp.quo[15:0];
               end
               done_in  = 1'b1;
               state_in = SG_IDLE;
            end
         end
         default: begin
            state_in = SG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      neg_ff  <= neg_in;
      a_ff    <= a_in;
      k_ff    <= k_in;
      b_ff    <= b_in;
      term_ff <= term_in;
      sum_ff  <= sum_in;
      n_ff    <= n_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign sig_rsp.done  = done_ff;
   assign sig_rsp.value = res_ff;

endmodule

FILE: design/linear_model_inference_top.sv
// Linear model inference: ring of accumulator cells fed by one shared MAC.
// Depends on lmi_pkg, lmi_ram, lmi_cell, lmi_sigmoid.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | func, row, column, weight, bias, feature
//   rsp     | out       | rsp_valid/stall    | output number, result, last flag
//   csr     | in        | csr_wr_en          | csr_index, csr_wdata
//
// A load item is written when it is accepted. A feature item passes through the accept,
// one weight read per output column, then the read latency, the multiply and the
// last ring shift. Each result then passes through the read, sum and calculate states;
// in classification mode the sigmoid unit, with its bit-serial divider, runs after them.
// Synchronous reset clears control state and the accumulators; no clearing pass.
// req_stall stays high until the last result beat of a sample is taken.
module linear_model_inference_top #(
   parameter int MAX_FEATURES = 64,
   parameter int MAX_OUTPUTS  = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [5:0]         req_row_index,
   input  logic [2:0]         req_column_index,
   input  logic signed [15:0] req_weight_value,
   input  logic signed [31:0] req_bias_value,
   input  logic signed [15:0] req_feature_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_output_number,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_last_output,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [6:0]         csr_wdata
);
   import lmi_pkg::*;

   localparam int WDEPTH = MAX_FEATURES * MAX_OUTPUTS;
   localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int JW     = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int FCW    = $clog2(MAX_FEATURES + 1);
   localparam int OCW    = $clog2(MAX_OUTPUTS + 1);

   lmi_state_type state_ff, state_in;
   logic                    task_mode_ff;
   logic [6:0]              fcount_ff;
   logic [3:0]              ocount_ff;
   logic [FCW-1:0]          fcnt_ff, fcnt_in;
   logic [JW-1:0]           j_ff, j_in;
   logic signed [15:0]      x_ff, x_in;
   logic                    rd_v_ff, rd_v_in;
   logic                    prod_v_ff, prod_v_in;
   logic signed [31:0]      prod_ff, prod_in;
   logic signed [SUM_W-1:0] s_ff, s_in;
   logic signed [31:0]      result_ff, result_in;

   logic [FCW-1:0]          nf_eff;
   logic [OCW-1:0]          no_eff;
   logic                    accept, last;
   logic                    w_we, b_we;
   logic [WAW-1:0]          w_waddr, w_raddr;
   logic signed [15:0]      w_rd;
   logic signed [31:0]      b_rd;
   logic signed [ACC_W-1:0] addend, head_sum;
   logic signed [ACC_W-1:0] cell_q [MAX_OUTPUTS];
   logic signed [ACC_W-1:0] cell_d [MAX_OUTPUTS];
   cell_ctl_type            cell_ctl;
   logic                    sig_start;
   sig_rsp_type             sig_rsp;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign w_we    = accept && (req_func == FUNC_WEIGHT)
                    && (int'(req_row_index) < MAX_FEATURES)
                    && (int'(req_column_index) < MAX_OUTPUTS);
   assign b_we    = accept && (req_func == FUNC_BIAS)
                    && (int'(req_column_index) < MAX_OUTPUTS);
   assign w_waddr = WAW'(int'(req_row_index) * MAX_OUTPUTS + int'(req_column_index));
   assign w_raddr = WAW'(int'(fcnt_ff) * MAX_OUTPUTS + int'(j_ff));

   lmi_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (req_weight_value),
      .rd_addr (w_raddr),
      .rd_data (w_rd)
   );

   lmi_ram #(.WIDTH(32), .DEPTH(MAX_OUTPUTS)) u_bias_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (JW'(req_column_index)),
      .wr_data (req_bias_value),
      .rd_addr (j_ff),
      .rd_data (b_rd)
   );

   // head of the ring adds the product, tail cell takes it back
   assign addend   = prod_v_ff ? ACC_W'(prod_ff) : '0;
   assign head_sum = cell_q[0] + addend;

   for (genvar i = 0; i < MAX_OUTPUTS; i++) begin : g_cell
      if (i == MAX_OUTPUTS - 1) begin : g_tail
         assign cell_d[i] = head_sum;
      end else begin : g_mid
         assign cell_d[i] = cell_q[i + 1];
      end
      lmi_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_ctl (cell_ctl),
         .cell_d   (cell_d[i]),
         .cell_q   (cell_q[i])
      );
   end

   lmi_sigmoid u_sigmoid (
      .clock     (clock),
      .reset     (reset),
      .sig_start (sig_start),
      .sig_arg   (s_ff),
      .sig_rsp   (sig_rsp)
   );

   always_comb begin
      if (fcount_ff == 7'd0) begin
         nf_eff = FCW'(1);
      end else if (int'(fcount_ff) > MAX_FEATURES) begin
         nf_eff = FCW'(MAX_FEATURES);
      end else begin
         nf_eff = FCW'(fcount_ff);
      end
      if (ocount_ff == 4'd0) begin
         no_eff = OCW'(1);
      end else if (int'(ocount_ff) > MAX_OUTPUTS) begin
         no_eff = OCW'(MAX_OUTPUTS);
      end else begin
         no_eff = OCW'(ocount_ff);
      end
   end

   assign last = (int'(j_ff) + 1) == int'(no_eff);

   always_comb begin
      state_in       = state_ff;
      fcnt_in        = fcnt_ff;
      j_in           = j_ff;
      x_in           = x_ff;
      s_in           = s_ff;
      result_in      = result_ff;
      rd_v_in        = (state_ff == ST_MAC);
      prod_v_in      = rd_v_ff;
      prod_in        = x_ff * w_rd;
      cell_ctl.shift = prod_v_ff || (state_ff == ST_OUT_SUM);
      cell_ctl.clear = 1'b0;
      sig_start      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_func == FUNC_FEATURE)) begin
               x_in     = req_feature_value;
               j_in     = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (int'(j_ff) == MAX_OUTPUTS - 1) begin
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // wait for the last product to enter the ring
            if (!rd_v_ff && !prod_v_ff) begin
               if ((int'(fcnt_ff) + 1) >= int'(nf_eff)) begin
                  fcnt_in  = '0;
                  j_in     = '0;
                  state_in = ST_OUT_RD;
               end else begin
                  fcnt_in  = FCW'(int'(fcnt_ff) + 1);
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_SUM;
         end
         ST_OUT_SUM: begin
            s_in     = SUM_W'(cell_q[0]) + SUM_W'(b_rd);
            state_in = ST_OUT_CALC;
         end
         ST_OUT_CALC: begin
            if (task_mode_ff) begin
               sig_start = 1'b1;
               state_in  = ST_OUT_SIG;
            end else begin
               if (s_ff > 49'sd2147483647) begin
                  result_in = 32'sh7FFF_FFFF;
               end else if (s_ff < -49'sd2147483648) begin
                  result_in = 32'sh8000_0000;
               end else begin
                  result_in = s_ff[31:0];
               end
               state_in = ST_OUT_VALID;
            end
         end
         ST_OUT_SIG: begin
            if (sig_rsp.done) begin
               result_in = {16'b0, sig_rsp.value};
               state_in  = ST_OUT_VALID;
            end
         end
         ST_OUT_VALID: begin
            if (!rsp_stall) begin
               if (last) begin
                  cell_ctl.clear = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fcnt_ff   <= '0;
         j_ff      <= '0;
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         fcnt_ff   <= fcnt_in;
         j_ff      <= j_in;
         rd_v_ff   <= rd_v_in;
         prod_v_ff <= prod_v_in;
      end
      x_ff      <= x_in;
      prod_ff   <= prod_in;
      s_ff      <= s_in;
      result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_mode_ff <= 1'b0;
         fcount_ff    <= 7'd64;
         ocount_ff    <= 4'd8;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TASK_MODE:     task_mode_ff <= csr_wdata[0];
            CSR_FEATURE_COUNT: fcount_ff    <= csr_wdata;
            CSR_OUTPUT_COUNT:  ocount_ff    <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid         = (state_ff == ST_OUT_VALID);
   assign rsp_output_number = 3'(j_ff);
   assign rsp_result_value  = result_ff;
   assign rsp_last_output   = last;

endmodule

FILE: design/lmi_checker.sv
// Port-level assertions for linear_model_inference_top, attached by bind.
// Depends on linear_model_inference_top_defines.svh.
`include "linear_model_inference_top_defines.svh"

module lmi_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_output_number,
   input logic signed [31:0] rsp_result_value,
   input logic               rsp_last_output
);

   // hold a stalled result beat
   `LMI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_value) && $stable(rsp_output_number) && $stable(rsp_last_output), "stalled result beat changed")

   // no request is taken while a result is pending
   `LMI_ASSERT_SAME(a_req_blocked, clock, reset, rsp_valid, req_stall, "request open while result pending")

   // the last beat of a sample ends the result burst
   `LMI_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && !rsp_stall && rsp_last_output, !rsp_valid, "result after last beat")

   // reset drops any result beat
   `LMI_ASSERT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid && !req_stall, "outputs active after reset")

endmodule

bind linear_model_inference_top lmi_checker u_lmi_checker (.*);
